[sv/lrc_pkg.sv]
// Shared register indexes and port widths for the line rectangle clipper.
package lrc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_FRAC  = 3'd4;

  localparam int EDGE_W = 16;
  localparam int SIZE_W = 15;
  localparam int FRAC_W = 5;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd8;

endpackage

[sv/lrc_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module lrc_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [NW-1:0] num_p;
    logic [NW-1:0] quo_p;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign den_p = den_i;
      assign num_p = num_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {rem_p, num_p[NW-1]};
    assign take  = trial >= {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
        den_q[k] <= den_p;
        num_q[k] <= num_p << 1;
        quo_q[k] <= {quo_p[NW-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

[sv/lrc_clip.sv]
// Two-stage cut of a segment to one axis span: multiply, then shift and add.
module lrc_clip #(
  parameter int WI  = 19,
  parameter int SW  = 33,
  parameter int FW  = 5,
  parameter int SBW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [WI-1:0] a_lo_i,
  input  logic signed [WI-1:0] b_lo_i,
  input  logic signed [WI-1:0] a_hi_i,
  input  logic signed [WI-1:0] b_hi_i,
  input  logic signed [WI-1:0] e1_i,
  input  logic signed [WI-1:0] e2_i,
  input  logic signed [SW-1:0] slope_i,
  input  logic [FW-1:0]        frac_i,
  input  logic [SBW-1:0]       sb_i,
  output logic                 valid_o,
  output logic signed [WI-1:0] a_lo_o,
  output logic signed [WI-1:0] b_lo_o,
  output logic signed [WI-1:0] a_hi_o,
  output logic signed [WI-1:0] b_hi_o,
  output logic [SBW-1:0]       sb_o
);

  localparam int PW = WI + SW;

  logic signed [WI-1:0] dlo, dhi;
  logic signed [PW-1:0] prod_lo_d, prod_hi_d;
  logic signed [PW-1:0] prod_lo_q, prod_hi_q;
  logic signed [WI-1:0] a_lo_q, b_lo_q, a_hi_q, b_hi_q;
  logic                 do_lo_q, do_hi_q, v1_q;
  logic [SBW-1:0]       sb1_q;
  logic signed [PW-1:0] sh_lo, sh_hi;

  logic                 v2_q;
  logic signed [WI-1:0] a_lo_o_q, b_lo_o_q, a_hi_o_q, b_hi_o_q;
  logic [SBW-1:0]       sb2_q;

  assign dlo       = e1_i - a_lo_i;
  assign dhi       = a_hi_i - e2_i;
  assign prod_lo_d = dlo * slope_i;
  assign prod_hi_d = dhi * slope_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      do_lo_q   <= a_lo_i < e1_i;
      do_hi_q   <= a_hi_i > e2_i;
      a_lo_q    <= a_lo_i;
      b_lo_q    <= b_lo_i;
      a_hi_q    <= a_hi_i;
      b_hi_q    <= b_hi_i;
      sb1_q     <= sb_i;
    end
  end

  assign sh_lo = prod_lo_q >>> frac_i;
  assign sh_hi = prod_hi_q >>> frac_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_lo_o_q <= do_lo_q ? e1_i : a_lo_q;
      b_lo_o_q <= do_lo_q ? b_lo_q + WI'(sh_lo) : b_lo_q;
      a_hi_o_q <= do_hi_q ? e2_i : a_hi_q;
      b_hi_o_q <= do_hi_q ? b_hi_q - WI'(sh_hi) : b_hi_q;
      sb2_q    <= sb1_q;
    end
  end

  assign valid_o = v2_q;
  assign a_lo_o  = a_lo_o_q;
  assign b_lo_o  = b_lo_o_q;
  assign a_hi_o  = a_hi_o_q;
  assign b_hi_o  = b_hi_o_q;
  assign sb_o    = sb2_q;

endmodule

[sv/line_rect_clipper.sv]
// Line segment clipper against a configured rectangle.
// Accepts one segment per cycle while the pipeline advances and returns one result
// per segment, in order. Between acceptance and result lie the input decode
// register, the two slope dividers, which resolve one quotient bit per pipeline
// stage, the x cut (multiply, shift-add), the y reorder, the y cut (multiply,
// shift-add) and the output register. The whole pipeline advances whenever
// the output register is empty or being taken.
// Write the configuration registers only while no segment is in flight.
module line_rect_clipper
  import lrc_pkg::*;
#(
  parameter int COORD_BITS    = 16,
  parameter int MAX_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // visible
  output logic                  m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int C   = COORD_BITS;
  localparam int F   = MAX_FRAC_BITS;
  localparam int WI  = ((C > EDGE_W) ? C : EDGE_W) + 3;
  localparam int NQ  = C + F;
  localparam int DW  = C + 1;
  localparam int SW  = NQ + 1;
  localparam int FW  = $clog2(F + 1);
  localparam int TDW = ((4 * C + 7) / 8) * 8;
  localparam logic signed [WI-1:0] CMAX = WI'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [WI-1:0] CMIN = -CMAX - WI'(1);

  typedef struct packed {
    logic [C-1:0]         sx;
    logic [C-1:0]         sy;
    logic [C-1:0]         ex;
    logic [C-1:0]         ey;
    logic signed [WI-1:0] lox;
    logic signed [WI-1:0] loy;
    logic signed [WI-1:0] hix;
    logic signed [WI-1:0] hiy;
    logic                 swp;
    logic                 vis;
    logic                 neg;
  } sb0_t;

  typedef struct packed {
    logic [4*C-1:0]       raw;
    logic                 swp;
    logic                 vis;
    logic signed [SW-1:0] slope_y;
  } sbx_t;

  typedef struct packed {
    logic [4*C-1:0] raw;
    logic           role;
    logic           vis;
  } sby_t;

  // configuration
  logic signed [EDGE_W-1:0] left_q, top_q;
  logic [SIZE_W-1:0]        width_q, height_q;
  logic [FRAC_W-1:0]        frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      frac_q   <= FRAC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLIP_LEFT:   left_q   <= cfg_data_i;
        REG_CLIP_TOP:    top_q    <= cfg_data_i;
        REG_CLIP_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_CLIP_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        REG_SLOPE_FRAC:  frac_q   <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [WI-1:0] x1, x2, y1, y2;
  logic [FW-1:0]        fr;

  assign x1 = WI'(left_q);
  assign y1 = WI'(top_q);
  assign x2 = x1 + signed'(WI'(width_q));
  assign y2 = y1 + signed'(WI'(height_q));
  assign fr = (32'(frac_q) > F) ? FW'(F) : FW'(frac_q);

  logic en;
  logic out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // input decode
  logic signed [C-1:0]  in_sx, in_sy, in_ex, in_ey;
  logic signed [WI-1:0] lox, loy, hix, hiy, dxw, dyw, adyw;
  logic                 swp;
  sb0_t                 sb0_d, sb0_q;
  logic                 v0_q;
  logic [NQ-1:0]        num_x_q, num_y_q;
  logic [DW-1:0]        den_x_q, den_y_q;

  assign in_sx = signed'(s_axis_tdata[C-1:0]);
  assign in_sy = signed'(s_axis_tdata[2*C-1:C]);
  assign in_ex = signed'(s_axis_tdata[3*C-1:2*C]);
  assign in_ey = signed'(s_axis_tdata[4*C-1:3*C]);

  assign swp  = in_ex < in_sx;
  assign lox  = WI'(swp ? in_ex : in_sx);
  assign loy  = WI'(swp ? in_ey : in_sy);
  assign hix  = WI'(swp ? in_sx : in_ex);
  assign hiy  = WI'(swp ? in_sy : in_ey);
  assign dxw  = hix - lox;
  assign dyw  = hiy - loy;
  assign adyw = (dyw < 0) ? -dyw : dyw;

  always_comb begin
    sb0_d.sx  = in_sx;
    sb0_d.sy  = in_sy;
    sb0_d.ex  = in_ex;
    sb0_d.ey  = in_ey;
    sb0_d.lox = lox;
    sb0_d.loy = loy;
    sb0_d.hix = hix;
    sb0_d.hiy = hiy;
    sb0_d.swp = swp;
    sb0_d.vis = !((lox >= x2) || (hix <= x1));
    sb0_d.neg = dyw < 0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb0_q   <= sb0_d;
      num_x_q <= NQ'(adyw[C-1:0]) << fr;
      den_x_q <= DW'(dxw[C-1:0]) + DW'(1);
      num_y_q <= NQ'(dxw[C-1:0]) << fr;
      den_y_q <= DW'(adyw[C-1:0]) + DW'(1);
    end
  end

  // slope dividers and matching delay line
  logic [NQ-1:0] qx, qy;

  lrc_div #(.NW(NQ), .DW(DW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_x_q),
    .den_i (den_x_q),
    .quo_o (qx)
  );

  lrc_div #(.NW(NQ), .DW(DW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_y_q),
    .den_i (den_y_q),
    .quo_o (qy)
  );

  logic dl_v_q  [NQ];
  sb0_t dl_sb_q [NQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NQ; k++) dl_v_q[k] <= 1'b0;
    end else if (en) begin
      dl_v_q[0] <= v0_q;
      for (int k = 1; k < NQ; k++) dl_v_q[k] <= dl_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_sb_q[0] <= sb0_q;
      for (int k = 1; k < NQ; k++) dl_sb_q[k] <= dl_sb_q[k-1];
    end
  end

  // x cut
  sb0_t                 sbd;
  sbx_t                 sbx_in, sbx_out;
  logic signed [SW-1:0] qx_s, slope_x;
  logic                 xc_v;
  logic signed [WI-1:0] xc_lox, xc_loy, xc_hix, xc_hiy;

  assign sbd     = dl_sb_q[NQ-1];
  assign qx_s    = signed'({1'b0, qx});
  assign slope_x = sbd.neg ? -qx_s : qx_s;

  always_comb begin
    sbx_in.raw     = {sbd.ey, sbd.ex, sbd.sy, sbd.sx};
    sbx_in.swp     = sbd.swp;
    sbx_in.vis     = sbd.vis;
    sbx_in.slope_y = signed'({1'b0, qy});
  end

  lrc_clip #(.WI(WI), .SW(SW), .FW(FW), .SBW($bits(sbx_t))) u_clip_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dl_v_q[NQ-1]),
    .a_lo_i  (sbd.lox),
    .b_lo_i  (sbd.loy),
    .a_hi_i  (sbd.hix),
    .b_hi_i  (sbd.hiy),
    .e1_i    (x1),
    .e2_i    (x2),
    .slope_i (slope_x),
    .frac_i  (fr),
    .sb_i    (sbx_in),
    .valid_o (xc_v),
    .a_lo_o  (xc_lox),
    .b_lo_o  (xc_loy),
    .a_hi_o  (xc_hix),
    .b_hi_o  (xc_hiy),
    .sb_o    (sbx_out)
  );

  // reorder by y
  logic                 ys;
  logic signed [WI-1:0] rlox, rloy, rhix, rhiy;
  logic                 r_v_q;
  logic signed [WI-1:0] r_lox_q, r_loy_q, r_hix_q, r_hiy_q;
  logic signed [SW-1:0] r_slope_q;
  sby_t                 r_sb_q;

  assign ys   = xc_hiy < xc_loy;
  assign rlox = ys ? xc_hix : xc_lox;
  assign rloy = ys ? xc_hiy : xc_loy;
  assign rhix = ys ? xc_lox : xc_hix;
  assign rhiy = ys ? xc_loy : xc_hiy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (en) begin
      r_v_q <= xc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_lox_q    <= rlox;
      r_loy_q    <= rloy;
      r_hix_q    <= rhix;
      r_hiy_q    <= rhiy;
      r_slope_q  <= ys ? -sbx_out.slope_y : sbx_out.slope_y;
      r_sb_q.raw <= sbx_out.raw;
      r_sb_q.role <= sbx_out.swp ^ ys;
      r_sb_q.vis <= sbx_out.vis && !((rloy >= y2) || (rhiy <= y1));
    end
  end

  // y cut
  logic                 yc_v;
  logic signed [WI-1:0] yc_loy, yc_lox, yc_hiy, yc_hix;
  sby_t                 sby_out;

  lrc_clip #(.WI(WI), .SW(SW), .FW(FW), .SBW($bits(sby_t))) u_clip_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r_v_q),
    .a_lo_i  (r_loy_q),
    .b_lo_i  (r_lox_q),
    .a_hi_i  (r_hiy_q),
    .b_hi_i  (r_hix_q),
    .e1_i    (y1),
    .e2_i    (y2),
    .slope_i (r_slope_q),
    .frac_i  (fr),
    .sb_i    (r_sb_q),
    .valid_o (yc_v),
    .a_lo_o  (yc_loy),
    .b_lo_o  (yc_lox),
    .a_hi_o  (yc_hiy),
    .b_hi_o  (yc_hix),
    .sb_o    (sby_out)
  );

  // output
  function automatic logic [C-1:0] sat(input logic signed [WI-1:0] v);
    logic signed [WI-1:0] r;
    r = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return r[C-1:0];
  endfunction

  logic [C-1:0]   lo_x, lo_y, hi_x, hi_y;
  logic [4*C-1:0] clip_word;
  logic [TDW-1:0] out_data_q;
  logic           out_vis_q;

  assign lo_x = sat(yc_lox);
  assign lo_y = sat(yc_loy);
  assign hi_x = sat(yc_hix);
  assign hi_y = sat(yc_hiy);
  assign clip_word = sby_out.role ? {lo_y, lo_x, hi_y, hi_x} : {hi_y, hi_x, lo_y, lo_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= yc_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_vis_q  <= sby_out.vis;
      out_data_q <= TDW'(sby_out.vis ? clip_word : sby_out.raw);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_vis_q;

endmodule
